### rtl/stepper_position_step_timer_defines.svh
// Assertion macros for the stepper position step timer RTL, used by stpt_core.
`ifndef STEPPER_POSITION_STEP_TIMER_DEFINES_SVH
`define STEPPER_POSITION_STEP_TIMER_DEFINES_SVH

`ifndef SYNTH
// Condition that must hold at every clock edge outside reset.
`define STPT_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Consequence that must hold in the cycle after the trigger.
`define STPT_ASSERT_NEXT(name, trig, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error(msg);
`else
`define STPT_ASSERT(name, cond, msg)
`define STPT_ASSERT_NEXT(name, trig, cons, msg)
`endif

`endif

### rtl/stpt_pkg.sv
// Types and constants shared by the stepper position step timer modules.
package stpt_pkg;

  localparam int POSITION_BITS_DEF = 32;
  localparam int ACCUM_BITS        = 18;
  localparam int DELAY_BITS        = 16;
  localparam int PHASE_COUNT       = 4;
  localparam int PHASE_BITS        = $clog2(PHASE_COUNT);
  localparam int OUT_POS_BITS      = 32;
  localparam int TARGET_BITS       = 32;

  localparam logic [DELAY_BITS-1:0]  STEP_DELAY_RESET = 16'd2000;
  localparam logic [PHASE_COUNT-1:0] COIL_RESET       = 4'b0001;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_TARGET = 2'd1,
    REQ_ZERO   = 2'd2
  } req_type_t;

  typedef struct packed {
    req_type_t              req_type;
    logic [DELAY_BITS-1:0]  elapsed_us;
    logic [TARGET_BITS-1:0] new_target;
  } item_t;

  typedef struct packed {
    logic [PHASE_COUNT-1:0]  coil_drive;
    logic [OUT_POS_BITS-1:0] step_position;
    logic                    at_target;
  } result_t;

endpackage

### rtl/stpt_core.sv
// Step timer state and per-word update: accumulator, position, target and coils.
`include "stepper_position_step_timer_defines.svh"

module stpt_core #(
  parameter int POSITION_BITS = stpt_pkg::POSITION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [stpt_pkg::DELAY_BITS-1:0]  cfg_wdata,
  input  logic                             fire,
  input  stpt_pkg::item_t                  item,
  output stpt_pkg::result_t                result
);
  import stpt_pkg::*;

  logic [DELAY_BITS-1:0]           step_delay;
  logic [ACCUM_BITS-1:0]           accum, accum_next;
  logic signed [POSITION_BITS-1:0] pos, pos_next;
  logic signed [POSITION_BITS-1:0] target, target_next;
  logic [PHASE_COUNT-1:0]          coil, coil_next;

  logic [ACCUM_BITS-1:0]           sum, delay_ext, rem;
  logic signed [POSITION_BITS-1:0] pos_up, pos_dn;
  logic [PHASE_COUNT-1:0]          old_bit, up_bit, dn_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_delay <= STEP_DELAY_RESET;
      accum      <= '0;
      pos        <= '0;
      target     <= '0;
      coil       <= COIL_RESET;
    end else begin
      if (cfg_we) begin
        step_delay <= cfg_wdata;
      end
      if (fire) begin
        accum  <= accum_next;
        pos    <= pos_next;
        target <= target_next;
        coil   <= coil_next;
      end
    end
  end

  always_comb begin
    accum_next  = accum;
    pos_next    = pos;
    target_next = target;
    coil_next   = coil;
    sum         = accum + ACCUM_BITS'(item.elapsed_us);
    delay_ext   = ACCUM_BITS'(step_delay);
    rem         = sum - delay_ext;
    pos_up      = pos + POSITION_BITS'(1);
    pos_dn      = pos - POSITION_BITS'(1);
    old_bit     = PHASE_COUNT'(1) << pos[PHASE_BITS-1:0];
    up_bit      = PHASE_COUNT'(1) << pos_up[PHASE_BITS-1:0];
    dn_bit      = PHASE_COUNT'(1) << pos_dn[PHASE_BITS-1:0];
    unique case (item.req_type)
      REQ_TICK: begin
        if (sum < delay_ext) begin
          accum_next = sum;
        end else begin
          // A remainder beyond a quarter delay is dropped to limit catch-up.
          accum_next = (rem > (delay_ext >> 2)) ? '0 : rem;
          if (pos < target) begin
            pos_next  = pos_up;
            coil_next = (coil & ~old_bit) | up_bit;
          end else if (pos > target) begin
            pos_next  = pos_dn;
            coil_next = (coil & ~old_bit) | dn_bit;
          end else begin
            coil_next = coil & ~old_bit;
          end
        end
      end
      REQ_TARGET: begin
        target_next = item.new_target[POSITION_BITS-1:0];
      end
      REQ_ZERO: begin
        pos_next    = '0;
        target_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign result.coil_drive    = coil_next;
  assign result.step_position = OUT_POS_BITS'(pos_next);
  assign result.at_target     = (pos_next == target_next);

  `STPT_ASSERT(a_accum_range, accum[ACCUM_BITS-1:DELAY_BITS] == '0, "accumulator exceeds 16 bits")
  `STPT_ASSERT_NEXT(a_zero_clears, fire && item.req_type == REQ_ZERO, pos == '0 && target == '0, "zero request did not clear position and target")
  `STPT_ASSERT_NEXT(a_no_time_off_tick, fire && item.req_type != REQ_TICK, $stable(accum), "accumulator moved on a non-tick word")
  `STPT_ASSERT_NEXT(a_single_step, fire && item.req_type == REQ_TICK, pos == $past(pos) || pos == $past(pos_up) || pos == $past(pos_dn), "position moved more than one step")
  `STPT_ASSERT_NEXT(a_idle_hold, !fire && !cfg_we, $stable(pos) && $stable(target) && $stable(coil), "state changed without a word")

endmodule

### rtl/stepper_position_step_timer.sv
// Each accepted word passes the input register, then the result register.
// Throughput: one word per cycle unless the consumer stalls; the input and result
// registers let a new word enter while a finished result waits for the consumer.
// Position, target, accumulator and coil state update in the single compute stage.
// Reset (rst, synchronous, active high) clears both valid stages, zeroes position,
// target and accumulator, turns on the phase zero coil and sets step_delay to 2000.
module stepper_position_step_timer #(
  parameter int POSITION_BITS = stpt_pkg::POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,      // step_delay
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // elapsed_us[15:0], new_target[47:16]
  input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // coil_drive[3:0], step_position[35:4],
                                      // at_target[36], zero[39:37]
);
  import stpt_pkg::*;

  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_res;
  result_t core_res;
  logic    advance;
  logic    fire;

  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign fire          = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.req_type   <= req_type_t'(s_axis_tuser);
      in_item.elapsed_us <= s_axis_tdata[15:0];
      in_item.new_target <= s_axis_tdata[47:16];
    end
    if (fire) begin
      out_res <= core_res;
    end
  end

  stpt_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (in_item),
    .result    (core_res)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_res.at_target, out_res.step_position, out_res.coil_drive};

endmodule

### sim/stepper_position_step_timer_checker.sv
// Watches the stepper timer channels, predicts each result word and compares.
module stepper_position_step_timer_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  output int          pending,
  output int          fail_count
);
  import stpt_pkg::*;

  typedef struct {
    logic [3:0]         coil_drive;
    logic signed [31:0] step_position;
    logic               at_target;
  } motor_state_t;

  motor_state_t expected_motor[$];

  logic [DELAY_BITS-1:0]  delay_us;
  logic [ACCUM_BITS-1:0]  accum_us;
  logic signed [31:0]     motor_pos;
  logic signed [31:0]     goal_pos;
  logic [PHASE_COUNT-1:0] coils;

  initial begin
    pending    = 0;
    fail_count = 0;
  end

  function automatic logic [PHASE_COUNT-1:0] phase_mask(input logic [31:0] p);
    return 4'b0001 << p[1:0];
  endfunction

  always @(posedge clk) begin
    req_type_t    req;
    motor_state_t got;
    motor_state_t want;
    int           bad;
    bad = 0;
    if (rst) begin
      delay_us  = STEP_DELAY_RESET;
      accum_us  = '0;
      motor_pos = '0;
      goal_pos  = '0;
      coils     = COIL_RESET;
      expected_motor.delete();
    end else begin
      if (cfg_we)
        delay_us = cfg_wdata;

      if (s_axis_tvalid && s_axis_tready) begin
        req = req_type_t'(s_axis_tuser);
        case (req)
          REQ_TICK: begin
            accum_us = accum_us + s_axis_tdata[15:0];
            if (accum_us >= delay_us) begin
              accum_us = accum_us - delay_us;
              // Catch-up limit: a large leftover is dropped, not carried.
              if (accum_us > (delay_us >> 2))
                accum_us = '0;
              coils = coils & ~phase_mask(motor_pos);
              if (motor_pos < goal_pos) begin
                motor_pos = motor_pos + 1;
                coils = coils | phase_mask(motor_pos);
              end else if (motor_pos > goal_pos) begin
                motor_pos = motor_pos - 1;
                coils = coils | phase_mask(motor_pos);
              end
            end
          end
          REQ_TARGET: goal_pos = s_axis_tdata[47:16];
          REQ_ZERO: begin
            motor_pos = '0;
            goal_pos  = '0;
          end
          default: ;
        endcase
        want.coil_drive    = coils;
        want.step_position = motor_pos;
        want.at_target     = (motor_pos == goal_pos);
        expected_motor.push_back(want);
      end

      if (m_axis_tvalid && m_axis_tready) begin
        got.coil_drive    = m_axis_tdata[3:0];
        got.step_position = m_axis_tdata[35:4];
        got.at_target     = m_axis_tdata[36];
        if (expected_motor.size() == 0) begin
          $error("result word arrived with no expectation pending");
          bad++;
        end else begin
          want = expected_motor.pop_front();
          if (got.coil_drive !== want.coil_drive) begin
            $error("coil_drive: expected %b, got %b", want.coil_drive, got.coil_drive);
            bad++;
          end
          if (got.step_position !== want.step_position) begin
            $error("step_position: expected %0d, got %0d",
                   want.step_position, got.step_position);
            bad++;
          end
          if (got.at_target !== want.at_target) begin
            $error("at_target: expected %b, got %b", want.at_target, got.at_target);
            bad++;
          end
        end
      end
    end
    pending    <= expected_motor.size();
    fail_count <= fail_count + bad;
  end

endmodule

### sim/stepper_position_step_timer_tb.sv
// Stimulus and verdict for the stepper position step timer.
module stepper_position_step_timer_tb;
  import stpt_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // elapsed_us[15:0], new_target[47:16]
  logic [1:0]  s_axis_tuser = '0;   // req_type[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // coil_drive[3:0], step_position[35:4], at_target[36]

  int pending;
  int fail_count;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int stall_span = 0;
  int stall_pct = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  stepper_position_step_timer u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  stepper_position_step_timer_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pending       (pending),
    .fail_count    (fail_count)
  );

  // The consumer switches at random between stall densities,
  // including stretches where it never stalls.
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_span <= $urandom_range(16, 96);
      case ($urandom_range(0, 4))
        0, 1: stall_pct <= 0;
        2: stall_pct <= 35;
        3: stall_pct <= 70;
        default: stall_pct <= 92;
      endcase
    end else begin
      stall_span <= stall_span - 1;
    end
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send_word(input logic [1:0] req, input logic [15:0] elapsed,
                           input logic [31:0] goal);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {goal, elapsed};
    s_axis_tuser  <= req;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_delay(input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [15:0] delays [7];
    logic [15:0] elapsed;
    logic [31:0] goal;
    int          lim;
    int          pick;
    int          counted;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset step delay of 2000 us.
    send_word(REQ_TICK, 16'd0, 32'h0);
    send_word(REQ_TARGET, 16'hFFFF, 32'd3);
    send_word(REQ_TICK, 16'd1999, 32'hFFFF_FFFF);
    send_word(REQ_TICK, 16'd1, 32'h0);
    send_word(REQ_TICK, 16'hFFFF, 32'h0);
    send_word(REQ_TICK, 16'd2500, 32'h0);
    send_word(REQ_TICK, 16'd1500, 32'h0);
    send_word(REQ_TICK, 16'd2000, 32'h0);
    send_word(REQ_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(REQ_ZERO, 16'hA5A5, 32'h1234_5678);
    send_word(REQ_TARGET, 16'h0, 32'h7FFF_FFFF);
    send_word(REQ_TICK, 16'd2000, 32'h0);
    send_word(REQ_TICK, 16'd2000, 32'h0);
    send_word(REQ_TARGET, 16'h0, 32'h8000_0000);
    send_word(REQ_TICK, 16'd2000, 32'h0);
    send_word(REQ_TICK, 16'd2000, 32'h0);
    send_word(REQ_TICK, 16'd2000, 32'h0);
    send_word(REQ_TARGET, 16'h0, 32'hFFFF_FFFE);
    send_word(REQ_TICK, 16'd2000, 32'h0);
    send_word(REQ_TICK, 16'd2000, 32'h0);
    send_word(REQ_TICK, 16'd2000, 32'h0);
    send_word(REQ_ZERO, 16'h0, 32'h0);
    send_word(REQ_TICK, 16'd2000, 32'h0);

    delays = '{16'd2000, 16'd0, 16'd1, 16'd7, 16'd65535, 16'd300, 16'd0};
    delays[6] = 16'($urandom_range(2, 5000));
    for (int ph = 0; ph < 7; ph++) begin
      drain();
      write_delay(delays[ph]);
      gaps_on = (ph != 2);
      counted = 0;
      while (counted < 64) begin
        if (ph == 3 && counted == 32)
          drain();
        elapsed = 16'($urandom_range(0, 65535));
        goal    = $urandom;
        pick    = $urandom_range(0, 99);
        if (pick < 8) begin
          send_word(REQ_TARGET, elapsed, goal);
        end else if (pick < 25) begin
          goal = $urandom_range(0, 32) - 16;
          send_word(REQ_TARGET, elapsed, goal);
        end else if (pick < 30) begin
          send_word(REQ_ZERO, elapsed, goal);
        end else if (pick < 33) begin
          // Unused code: the block keeps its state but still returns a result word; not counted.
          send_word(REQ_UNUSED, elapsed, goal);
          continue;
        end else begin
          if ($urandom_range(0, 9) != 0) begin
            lim = (delays[ph] == 0) ? 3 : delays[ph] + delays[ph] / 2;
            if (lim > 65535) lim = 65535;
            elapsed = 16'($urandom_range(0, lim));
          end
          send_word(REQ_TICK, elapsed, goal);
        end
        counted++;
      end
    end

    drain();
    repeat (5) @(posedge clk);
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #7200000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
